// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the ring buffer deque.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// File: rtl/rbd_pkg.sv
// Types and codes of the ring buffer deque.
// No dependencies; used by the top level by scoped names.
`default_nettype none
package rbd_pkg;

   typedef enum logic [1:0] {
      REQ_PUSH_FRONT,
      REQ_PUSH_BACK,
      REQ_POP_FRONT,
      REQ_POP_BACK
   } req_op_type;

   typedef enum logic [1:0] {
      ERR_OK,
      ERR_OVERFLOW,
      ERR_UNDERFLOW
   } op_err_type;

   localparam int unsigned FIELD_W = 32;

endpackage
`default_nettype wire

// File: rtl/rbd_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module rbd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_a_addr,
   output logic      [WIDTH-1:0]  rd_a_data,
   input  wire logic [ADDR_W-1:0] rd_b_addr,
   output logic      [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_data <= mem_ff[rd_a_addr];
      rd_b_data <= mem_ff[rd_b_addr];
   end

endmodule
`default_nettype wire

// File: rtl/ring_buffer_deque_top.sv
// Ring buffer deque top level: index and count control around the item RAM.
// Depends on rbd_pkg, rbd_ram and assert_macros.svh.
//
// Usage:
//   Request channel: drive req_type, req_item_data and req_batch_last with
//   start high; the item is taken at the clock edge where busy is low. busy
//   stays low, so one push or pop is taken every cycle.
//   Result channel: rsp_valid is high for exactly one cycle, the cycle right
//   after the accepting edge, with front and back items, count, empty and
//   full flags and the error code. The items come from the registered read
//   of the two-read-port item RAM; throughput is one item per cycle.
//   A push to a full deque is dropped with overflow; a pop from an empty
//   deque is dropped with underflow. Front and back items read 0 when empty.
//   The receiver cannot stall; each result must be taken when shown.
//   Reset (synchronous, active high) empties the deque: front index 0,
//   back index DEPTH-1, count 0. The RAM is not cleared; only written
//   entries are ever reported.
`default_nettype none
`include "assert_macros.svh"
module ring_buffer_deque_top #(
   parameter int unsigned DEPTH      = 256,
   parameter int unsigned DATA_WIDTH = 32,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_type,
   input  wire logic [rbd_pkg::FIELD_W-1:0] req_item_data,
   input  wire logic                        req_batch_last,
   output logic                             rsp_valid,
   output logic      [rbd_pkg::FIELD_W-1:0] rsp_front_item,
   output logic      [rbd_pkg::FIELD_W-1:0] rsp_back_item,
   output logic      [CNT_W-1:0]            rsp_item_count,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full,
   output logic      [1:0]                  rsp_op_error
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [IDX_W-1:0]       front_ff, front_in;
   logic [IDX_W-1:0]       back_ff, back_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff;
   rbd_pkg::op_err_type    err_ff, err_in;
   logic                   fbyp_ff, bbyp_ff;
   logic [DATA_WIDTH-1:0]  wdata_ff;

   logic                   accept;
   logic                   full, empty;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic [DATA_WIDTH-1:0]  rd_front, rd_back;
   logic [DATA_WIDTH-1:0]  front_val, back_val;

   function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_LAST : i - IDX_W'(1);
   endfunction

   assign busy    = 1'b0;
   assign accept  = start & ~busy;
   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign wr_data = DATA_WIDTH'(req_item_data);

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      err_in   = rbd_pkg::ERR_OK;
      wr_en    = 1'b0;
      wr_addr  = idx_down(front_ff);
      if (accept) begin
         case (rbd_pkg::req_op_type'(req_type))
            rbd_pkg::REQ_PUSH_FRONT: begin
               if (full) begin
                  err_in = rbd_pkg::ERR_OVERFLOW;
               end else begin
                  front_in = idx_down(front_ff);
                  wr_en    = 1'b1;
                  wr_addr  = front_in;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            rbd_pkg::REQ_PUSH_BACK: begin
               if (full) begin
                  err_in = rbd_pkg::ERR_OVERFLOW;
               end else begin
                  back_in  = idx_up(back_ff);
                  wr_en    = 1'b1;
                  wr_addr  = back_in;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            rbd_pkg::REQ_POP_FRONT: begin
               if (empty) begin
                  err_in = rbd_pkg::ERR_UNDERFLOW;
               end else begin
                  front_in = idx_up(front_ff);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               if (empty) begin
                  err_in = rbd_pkg::ERR_UNDERFLOW;
               end else begin
                  back_in  = idx_down(back_ff);
                  count_in = count_ff - CNT_W'(1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= IDX_LAST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= rbd_pkg::ERR_OK;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         err_ff       <= err_in;
      end
   end

   // RAM read misses a write on the same edge: forward the written item
   always_ff @(posedge clock) begin
      fbyp_ff  <= wr_en && (wr_addr == front_in);
      bbyp_ff  <= wr_en && (wr_addr == back_in);
      wdata_ff <= wr_data;
   end

   rbd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (front_in),
      .rd_a_data (rd_front),
      .rd_b_addr (back_in),
      .rd_b_data (rd_back)
   );

   assign front_val      = fbyp_ff ? wdata_ff : rd_front;
   assign back_val       = bbyp_ff ? wdata_ff : rd_back;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_front_item = empty ? '0 : rbd_pkg::FIELD_W'(front_val);
   assign rsp_back_item  = empty ? '0 : rbd_pkg::FIELD_W'(back_val);
   assign rsp_item_count = count_ff;
   assign rsp_is_empty   = empty;
   assign rsp_is_full    = full;
   assign rsp_op_error   = err_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_FULL, "count above depth")
   `ASSERT_AT(a_ovf_full, clock, reset, (rsp_valid && rsp_op_error == rbd_pkg::ERR_OVERFLOW) |-> full, "overflow while not full")
   `ASSERT_AT(a_udf_empty, clock, reset, (rsp_valid && rsp_op_error == rbd_pkg::ERR_UNDERFLOW) |-> empty, "underflow while not empty")
   `ASSERT_AT(a_push_grows, clock, reset, (accept && !full && (req_type == rbd_pkg::REQ_PUSH_FRONT || req_type == rbd_pkg::REQ_PUSH_BACK)) |=> (count_ff == $past(count_ff) + CNT_W'(1)), "push did not grow count")
   `ASSERT_AT(a_reset_quiet, clock, 1'b0, $past(reset) |-> !rsp_valid, "result after reset")

endmodule
`default_nettype wire
